// File: rtl/core/ocm_pkg.sv
`timescale 1ns / 1ps
package ocm_pkg;
	localparam int unsigned W = 32;
	localparam logic [16:0] BETA_ONE = 17'd65536;
	localparam logic [16:0] K_SHRINK = 17'd45875;
	localparam logic [16:0] K_GROW = 17'd70124;
	localparam logic [16:0] K_LOWDECAY = 17'd64881;
	localparam logic [16:0] K_UPGROW = 17'd66191;

	typedef enum logic [2:0] {
		REG_INIT = 3'd0,
		REG_SPREAD = 3'd1,
		REG_BETA = 3'd2,
		REG_MAX = 3'd3,
		REG_MIN = 3'd4,
		REG_GTHR = 3'd5,
		REG_STHR = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic start;
		logic [63:0] num;
		logic [32:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [63:0] quo;
	} div_rsp_t;
endpackage

// File: rtl/core/optimizer_convergence_monitor_unit.sv
`timescale 1ns / 1ps
// Channel  | Direction | Beat contents (lowest bits first)
// s_axis   | in        | tdata: step_index, gradient_norm, score; tuser: cmd, score_valid
// m_axis   | out       | tdata: step_size, stop_step, trigger_gradient, trigger_score_change
// cfg      | in        | cfg_index, cfg_data
// An iteration with a score uses the 64-step serial divider twice (score change and step
// scaling); a zero previous score or a zero base step size skips one division. Without a
// score, or at step zero, it uses no division. A clear uses the divider for the lower bound,
// unless the spread is zero. Reset loads the register defaults and their derived bounds over
// the same sequence. s_axis_tready is low from acceptance until the result beat is taken.
module optimizer_convergence_monitor_unit #(
	parameter int STEP_BITS = 20
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// step_index, gradient_norm, score, zero fill (lowest first)
	input logic [((STEP_BITS + 64 + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// cmd, score_valid (lowest first)
	input logic [1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// step_size, stop_step, trigger_gradient, trigger_score_change, zero fill
	output logic [((STEP_BITS + 96 + 7) / 8) * 8 - 1:0] m_axis_tdata,
	// converged, hit_step_limit, gradient_settled, score_settled (lowest first)
	output logic [3:0] m_axis_tuser,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data
);
	import ocm_pkg::*;
	localparam int OW = ((STEP_BITS + 96 + 7) / 8) * 8;

	typedef enum logic [15:0] {
		S_IDLE = 16'h0001, S_CLR = 16'h0002, S_CLRDIV = 16'h0004,
		S_DLT = 16'h0008, S_DLTW = 16'h0010, S_SCL = 16'h0020,
		S_SCLDIV = 16'h0040, S_SAVG = 16'h0080, S_STST = 16'h0100,
		S_TRND = 16'h0200, S_TCLP = 16'h0400, S_GAVG = 16'h0800,
		S_GTST = 16'h1000, S_FIN = 16'h2000, S_OUT = 16'h4000,
		S_SAVG2 = 16'h8000
	} state_t;
	state_t st_q;

	logic [31:0] init_q, spread_q, gthr_q, sthr_q;
	logic [15:0] beta_q;
	logic [STEP_BITS-1:0] max_q, min_q;

	logic signed [31:0] prev_q;
	logic [31:0] gavg_q, savg_q, cur_q, up_q, lo_q, fgr_q, fsc_q;
	logic [15:0] bpow_q;
	logic signed [4:0] trend_q;
	logic lim_q, grf_q, scf_q, stop_q;
	logic [STEP_BITS-1:0] sidx_q;

	logic sv_q;
	logic [STEP_BITS-1:0] l_q;
	logic [31:0] grad_q, delta_q, scaled_q;
	logic signed [31:0] score_q;
	logic [63:0] acc_q;
	logic ph_q;
	logic pending_q;

	// Shared multiplier: one 33x33 product per cycle.
	logic [32:0] ma, mb;
	logic [65:0] prod;
	assign prod = ma * mb;

	div_req_t dreq;
	div_rsp_t drsp;
	ocm_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	function automatic logic [31:0] sat32(input logic [65:0] v);
		return (|v[65:32]) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	logic [32:0] dabs, pabs;
	logic signed [32:0] dsc;
	always_comb begin
		dsc = 33'(score_q) - 33'(prev_q);
		dabs = dsc[32] ? 33'(-dsc) : dsc;
		pabs = prev_q[31] ? 33'(-34'(prev_q)) : 33'(prev_q);
	end

	logic [65:0] rnd;
	assign rnd = (prod + 66'd32768) >> 16;
	logic [4:0] tr_up, tr_dn;
	assign tr_up = trend_q + 5'sd2;
	assign tr_dn = trend_q - 5'sd1;
	logic [16:0] omb, ombp;
	assign omb = BETA_ONE - {1'b0, beta_q};
	assign ombp = BETA_ONE - {1'b0, bpow_q};

	always_comb begin
		ma = '0;
		mb = '0;
		dreq = '0;
		unique case (st_q)
			S_CLR: begin ma = {1'b0, init_q}; mb = {1'b0, spread_q}; end
			S_SCL: begin ma = {1'b0, delta_q}; mb = {1'b0, cur_q}; end
			S_SAVG: begin ma = {17'd0, beta_q}; mb = {1'b0, savg_q}; end
			S_SAVG2: begin ma = {16'd0, omb}; mb = {1'b0, scaled_q}; end
			S_STST: begin ma = {1'b0, sthr_q}; mb = {16'd0, ombp}; end
			S_TRND: begin
				ma = {1'b0, cur_q};
				mb = {16'd0, (score_q > prev_q) ? K_SHRINK : K_GROW};
			end
			S_TCLP: begin
				ma = {1'b0, (score_q > prev_q) ? lo_q : up_q};
				mb = {16'd0, (score_q > prev_q) ? K_LOWDECAY : K_UPGROW};
			end
			S_GAVG: begin
				ma = ph_q ? {16'd0, omb} : {17'd0, beta_q};
				mb = {1'b0, ph_q ? grad_q : gavg_q};
			end
			S_GTST: begin ma = {1'b0, gthr_q}; mb = {16'd0, ombp}; end
			S_FIN: begin ma = {17'd0, bpow_q}; mb = {17'd0, beta_q}; end
			default: ;
		endcase
		if (st_q == S_CLR && spread_q != 0) begin
			dreq.start = 1'b1;
			dreq.num = {16'd0, init_q, 16'd0};
			dreq.den = {1'b0, spread_q};
		end
		if (st_q == S_DLT && prev_q != 0) begin
			dreq.start = 1'b1;
			dreq.num = {15'd0, dabs, 16'd0};
			dreq.den = pabs;
		end
		if (st_q == S_SCL && init_q != 0) begin
			dreq.start = 1'b1;
			dreq.num = prod[63:0];
			dreq.den = {1'b0, init_q};
		end
	end

	assign s_axis_tready = (st_q == S_IDLE) && !pending_q;
	assign cfg_ready = 1'b1;
	// Reset-time initialization runs without presenting a result beat.
	assign m_axis_tvalid = (st_q == S_OUT) && !pending_q;
	assign m_axis_tuser = {scf_q, grf_q, lim_q, stop_q};
	assign m_axis_tdata = OW'({fsc_q, fgr_q, sidx_q, cur_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			pending_q <= 1'b1;
			init_q <= 32'd65536; spread_q <= 32'd655360; beta_q <= 16'd58982;
			max_q <= STEP_BITS'(1000); min_q <= STEP_BITS'(10);
			gthr_q <= 32'd66; sthr_q <= 32'd66;
			ph_q <= 1'b0;
			trend_q <= '0; lim_q <= 1'b0; grf_q <= 1'b0; scf_q <= 1'b0; stop_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_INIT: init_q <= cfg_data;
					REG_SPREAD: spread_q <= cfg_data;
					REG_BETA: beta_q <= cfg_data[15:0];
					REG_MAX: max_q <= cfg_data[STEP_BITS-1:0];
					REG_MIN: min_q <= cfg_data[STEP_BITS-1:0];
					REG_GTHR: gthr_q <= cfg_data;
					REG_STHR: sthr_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (st_q)
				S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					sv_q <= s_axis_tuser[1];
					l_q <= s_axis_tdata[STEP_BITS-1:0];
					grad_q <= s_axis_tdata[STEP_BITS+31:STEP_BITS];
					score_q <= s_axis_tdata[STEP_BITS+63:STEP_BITS+32];
					ph_q <= 1'b0;
					if (!s_axis_tuser[0]) st_q <= S_CLR;
					else if (s_axis_tuser[1] && s_axis_tdata[STEP_BITS-1:0] != 0)
						st_q <= S_DLT;
					else if (s_axis_tuser[1]) st_q <= S_TRND;
					else st_q <= S_GAVG;
				end
				S_CLR: begin
					prev_q <= '0; gavg_q <= '0; savg_q <= '0;
					bpow_q <= beta_q; cur_q <= init_q;
					up_q <= sat32(rnd);
					lo_q <= 32'hFFFF_FFFF;
					trend_q <= '0; lim_q <= 1'b0; grf_q <= 1'b0; scf_q <= 1'b0;
					stop_q <= 1'b0; sidx_q <= '0; fgr_q <= '0; fsc_q <= '0;
					st_q <= (spread_q != 0) ? S_CLRDIV : S_OUT;
				end
				S_CLRDIV: if (drsp.done) begin
					lo_q <= sat32({2'b0, drsp.quo});
					st_q <= S_OUT;
				end
				S_DLT: begin
					if (prev_q == 0) begin
						delta_q <= 32'hFFFF_FFFF;
						st_q <= S_SCL;
					end else st_q <= S_DLTW;
				end
				S_DLTW: if (drsp.done) begin
					delta_q <= sat32({2'b0, drsp.quo});
					st_q <= S_SCL;
				end
				S_SCL: begin
					scaled_q <= delta_q;
					st_q <= (init_q != 0) ? S_SCLDIV : S_SAVG;
				end
				S_SCLDIV: if (drsp.done) begin
					scaled_q <= sat32({2'b0, drsp.quo});
					st_q <= S_SAVG;
				end
				S_SAVG: begin acc_q <= prod[63:0]; st_q <= S_SAVG2; end
				S_SAVG2: begin
					savg_q <= 32'((acc_q + prod[63:0] + 64'd32768) >> 16);
					st_q <= S_STST;
				end
				S_STST: begin
					if ({savg_q, 16'd0} < prod[63:0]) begin
						fsc_q <= delta_q;
						scf_q <= 1'b1;
					end
					st_q <= S_TRND;
				end
				S_TRND: begin
					st_q <= S_GAVG;
					if (score_q > prev_q) begin
						if ($signed(tr_up) >= 5'sd10) begin
							trend_q <= '0;
							if (sat32(rnd) < lo_q) begin
								cur_q <= lo_q; st_q <= S_TCLP;
							end else cur_q <= sat32(rnd);
						end else trend_q <= tr_up;
					end else begin
						if ($signed(tr_dn) == -5'sd2) begin
							trend_q <= '0;
							if (sat32(rnd) > up_q) begin
								cur_q <= up_q; st_q <= S_TCLP;
							end else cur_q <= sat32(rnd);
						end else trend_q <= tr_dn;
					end
				end
				S_TCLP: begin
					if (score_q > prev_q) lo_q <= sat32(rnd);
					else up_q <= sat32(rnd);
					st_q <= S_GAVG;
				end
				S_GAVG: begin
					if (sv_q) prev_q <= score_q;
					ph_q <= ~ph_q;
					if (!ph_q) acc_q <= prod[63:0];
					else begin
						gavg_q <= 32'((acc_q + prod[63:0] + 64'd32768) >> 16);
						if (l_q >= max_q) lim_q <= 1'b1;
						st_q <= S_GTST;
					end
				end
				S_GTST: begin
					if ({gavg_q, 16'd0} < prod[63:0]) begin
						fgr_q <= grad_q;
						grf_q <= 1'b1;
					end
					st_q <= S_FIN;
				end
				S_FIN: begin
					stop_q <= (lim_q || grf_q || scf_q) && (l_q > min_q);
					if ((lim_q || grf_q || scf_q) && (l_q > min_q)) begin
						sidx_q <= l_q;
						cur_q <= init_q;
					end
					bpow_q <= rnd[15:0];
					st_q <= S_OUT;
				end
				S_OUT: begin
					if (pending_q) begin
						pending_q <= 1'b0;
						st_q <= S_IDLE;
					end else if (m_axis_tready) st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_one_hot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(st_q))
		else $error("state not one-hot");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready && !pending_q) |=> m_axis_tvalid)
		else $error("result dropped");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(drsp.busy || drsp.done) |->
		(st_q == S_CLRDIV || st_q == S_DLTW || st_q == S_SCLDIV))
		else $error("divider result unclaimed");
endmodule

// File: rtl/core/ocm_div.sv
`timescale 1ns / 1ps
module ocm_div (
	input logic clk,
	input logic arst_n,
	input ocm_pkg::div_req_t req,
	output ocm_pkg::div_rsp_t rsp
);
	import ocm_pkg::*;

	// Restoring divider, one quotient bit per cycle.
	logic [63:0] quo_q;
	logic [32:0] den_q;
	logic [33:0] rem_q;
	logic [6:0] cnt_q;
	logic busy_q, done_q;
	logic [33:0] shifted;
	logic [34:0] diff;

	always_comb begin
		shifted = {rem_q[32:0], quo_q[63]};
		diff = {1'b0, shifted} - {2'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[34]) begin
				rem_q <= diff[33:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo = quo_q;
endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import ocm_pkg::*;

	localparam int STEP_W = 20;
	localparam int IN_W = ((STEP_W + 64 + 7) / 8) * 8;
	localparam int OUT_W = ((STEP_W + 96 + 7) / 8) * 8;
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam logic CMD_CLEAR = 1'b0;
	localparam logic CMD_STEP = 1'b1;
	localparam logic [63:0] ALL32 = 64'hFFFF_FFFF;
	localparam logic [63:0] Q_ONE = 64'd65536;

	typedef struct packed {
		logic converged;
		logic [31:0] step_size;
		logic hit_limit;
		logic grad_settled;
		logic score_settled;
		logic [19:0] stop_step;
		logic [31:0] trig_grad;
		logic [31:0] trig_score;
	} monitor_out_t;

	typedef struct {
		logic cmd;
		logic [19:0] idx;
		logic [31:0] grad;
		logic [31:0] score;
		logic sv;
		bit fixed;
		monitor_out_t out;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [3:0] m_axis_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	optimizer_convergence_monitor_unit #(.STEP_BITS(STEP_W)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Mirror of the monitor registers and state.
	logic [63:0] r_init, r_spread, r_beta, r_max, r_min, r_gthr, r_sthr;
	longint prev_score;
	logic [63:0] grad_avg, score_avg, beta_pow, cur_step, upper_bound, lower_bound;
	int trend;
	bit lim_flag, grad_flag, score_flag, stop_flag;
	logic [63:0] stop_idx, fired_grad, fired_score;

	monitor_out_t pending_q[$];
	stim_row_t rows[$];
	int errors = 0;
	bit calm = 0;
	bit hold_long = 0;

	function automatic logic [63:0] sat32(input logic [63:0] v);
		return (v > ALL32) ? ALL32 : v;
	endfunction

	function automatic logic [63:0] scale_k(input logic [63:0] x, input logic [16:0] k);
		return sat32((x * {47'd0, k} + 64'd32768) >> 16);
	endfunction

	function automatic logic [63:0] ewma(input logic [63:0] avg, input logic [63:0] x);
		return (r_beta * avg + (Q_ONE - r_beta) * x + 64'd32768) >> 16;
	endfunction

	function automatic bit below_thr(input logic [63:0] avg, input logic [63:0] thr);
		return (avg << 16) < thr * (Q_ONE - beta_pow);
	endfunction

	task automatic monitor_clear();
		prev_score = 0;
		grad_avg = 0;
		score_avg = 0;
		beta_pow = r_beta;
		cur_step = r_init;
		upper_bound = sat32((r_init * r_spread + 64'd32768) >> 16);
		if (r_spread == 0) begin
			lower_bound = ALL32;
		end else begin
			lower_bound = sat32((r_init << 16) / r_spread);
		end
		trend = 0;
		lim_flag = 0;
		grad_flag = 0;
		score_flag = 0;
		stop_flag = 0;
		stop_idx = 0;
		fired_grad = 0;
		fired_score = 0;
	endtask

	task automatic monitor_write(input logic [2:0] idx, input logic [31:0] val);
		case (idx)
			REG_INIT: r_init = {32'd0, val};
			REG_SPREAD: r_spread = {32'd0, val};
			REG_BETA: r_beta = {48'd0, val[15:0]};
			REG_MAX: r_max = {44'd0, val[19:0]};
			REG_MIN: r_min = {44'd0, val[19:0]};
			REG_GTHR: r_gthr = {32'd0, val};
			REG_STHR: r_sthr = {32'd0, val};
			default: ;
		endcase
	endtask

	task automatic monitor_iterate(input stim_row_t it, output monitor_out_t res);
		logic [63:0] step_l, grad, delta, scaled, mag, pmag;
		longint sc, diff;
		step_l = {44'd0, it.idx};
		grad = {32'd0, it.grad};
		sc = longint'($signed(it.score));
		if (it.cmd == CMD_CLEAR) begin
			monitor_clear();
		end else begin
			if (it.sv) begin
				if (step_l > 0) begin
					if (prev_score == 0) begin
						delta = ALL32;
					end else begin
						diff = sc - prev_score;
						mag = (diff < 0) ? -diff : diff;
						pmag = (prev_score < 0) ? -prev_score : prev_score;
						delta = sat32((mag << 16) / pmag);
					end
					if (r_init == 0) begin
						scaled = delta;
					end else begin
						scaled = sat32((delta * cur_step) / r_init);
					end
					score_avg = ewma(score_avg, scaled);
					if (below_thr(score_avg, r_sthr)) begin
						fired_score = delta;
						score_flag = 1;
					end
				end
				// Rising scores tighten the step; non-rises loosen it when the trend hits -2.
				if (sc > prev_score) begin
					trend += 2;
					if (trend >= 10) begin
						trend = 0;
						cur_step = scale_k(cur_step, K_SHRINK);
						if (cur_step < lower_bound) begin
							cur_step = lower_bound;
							lower_bound = scale_k(lower_bound, K_LOWDECAY);
						end
					end
				end else begin
					trend -= 1;
					if (trend == -2) begin
						trend = 0;
						cur_step = scale_k(cur_step, K_GROW);
						if (cur_step > upper_bound) begin
							cur_step = upper_bound;
							upper_bound = scale_k(upper_bound, K_UPGROW);
						end
					end
				end
				prev_score = sc;
			end
			if (step_l >= r_max) begin
				lim_flag = 1;
			end
			grad_avg = ewma(grad_avg, grad);
			if (below_thr(grad_avg, r_gthr)) begin
				fired_grad = grad;
				grad_flag = 1;
			end
			stop_flag = (lim_flag || grad_flag || score_flag) && step_l > r_min;
			if (stop_flag) begin
				stop_idx = step_l;
				cur_step = r_init;
			end
			beta_pow = (beta_pow * r_beta + 64'd32768) >> 16;
		end
		res.converged = stop_flag;
		res.step_size = cur_step[31:0];
		res.hit_limit = lim_flag;
		res.grad_settled = grad_flag;
		res.score_settled = score_flag;
		res.stop_step = stop_idx[19:0];
		res.trig_grad = fired_grad[31:0];
		res.trig_score = fired_score[31:0];
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic add_row(input logic cmd, input logic [19:0] idx, input logic [31:0] grad,
			input logic [31:0] score, input logic sv, input bit fixed, input monitor_out_t out);
		stim_row_t r;
		r.cmd = cmd;
		r.idx = idx;
		r.grad = grad;
		r.score = score;
		r.sv = sv;
		r.fixed = fixed;
		r.out = out;
		rows.push_back(r);
	endtask

	// Leaves tvalid high so that a back-to-back beat never toggles it within a step.
	task automatic send_beat(input stim_row_t it);
		int gap;
		monitor_out_t res;
		gap = calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_W - 84){1'b0}}, it.score, it.grad, it.idx};
		s_axis_tuser <= {it.sv, it.cmd};
		do @(posedge clk); while (!s_axis_tready);
		monitor_iterate(it, res);
		pending_q.push_back(it.fixed ? it.out : res);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		monitor_write(idx, val);
	endtask

	task automatic configure(input int phase);
		logic [31:0] v[7];
		int i;
		case (phase)
			1: v = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
			2: v = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h000F_FFFF,
				32'h000F_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
			3: v = '{32'd65536, 32'd65536, 32'd32768, 32'd40, 32'd5, 32'd1000, 32'd30000};
			4: v = '{$urandom_range(1, 32'h0004_0000), $urandom_range(0, 65535),
				$urandom_range(50000, 65535), $urandom_range(0, 80), $urandom_range(0, 20),
				$urandom_range(0, 5000), $urandom_range(0, 200000)};
			default: v = '{$urandom, $urandom_range(65536, 32'h0010_0000), $urandom,
				$urandom_range(0, 300), $urandom_range(0, 30), $urandom_range(0, 1 << 20),
				$urandom_range(0, 1 << 18)};
		endcase
		for (i = 0; i < 7; i++) begin
			write_reg(i[2:0], v[i]);
		end
		write_reg(REG_UNUSED, $urandom);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Result side: random back-pressure, plus one long hold-off on request.
	initial begin
		int stall;
		monitor_out_t got, want;
		m_axis_tready = 1'b0;
		forever begin
			stall = calm ? 0 : $urandom_range(0, 15);
			if (hold_long) begin
				stall = 400;
				hold_long = 0;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got.converged = m_axis_tuser[0];
			got.hit_limit = m_axis_tuser[1];
			got.grad_settled = m_axis_tuser[2];
			got.score_settled = m_axis_tuser[3];
			got.step_size = m_axis_tdata[31:0];
			got.stop_step = m_axis_tdata[51:32];
			got.trig_grad = m_axis_tdata[83:52];
			got.trig_score = m_axis_tdata[115:84];
			if (pending_q.size() == 0) begin
				report("unexpected beat", 32'd0, 32'd0);
			end else begin
				want = pending_q.pop_front();
				if (got.converged !== want.converged)
					report("converged", 32'(got.converged), 32'(want.converged));
				if (got.step_size !== want.step_size)
					report("step_size", got.step_size, want.step_size);
				if (got.hit_limit !== want.hit_limit)
					report("hit_step_limit", 32'(got.hit_limit), 32'(want.hit_limit));
				if (got.grad_settled !== want.grad_settled)
					report("gradient_settled", 32'(got.grad_settled),
						32'(want.grad_settled));
				if (got.score_settled !== want.score_settled)
					report("score_settled", 32'(got.score_settled),
						32'(want.score_settled));
				if (got.stop_step !== want.stop_step)
					report("stop_step", 32'(got.stop_step), 32'(want.stop_step));
				if (got.trig_grad !== want.trig_grad)
					report("trigger_gradient", got.trig_grad, want.trig_grad);
				if (got.trig_score !== want.trig_score)
					report("trigger_score_change", got.trig_score, want.trig_score);
			end
		end
	end

	initial begin
		monitor_out_t cleared, none;
		stim_row_t it;
		int n, len, gmode, k, phase;
		logic [31:0] sc, g;
		logic [19:0] base;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		r_init = 64'd65536;
		r_spread = 64'd655360;
		r_beta = 64'd58982;
		r_max = 64'd1000;
		r_min = 64'd10;
		r_gthr = 64'd66;
		r_sthr = 64'd66;
		monitor_clear();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part under the default registers.
		cleared = '{1'b0, 32'd65536, 1'b0, 1'b0, 1'b0, 20'd0, 32'd0, 32'd0};
		none = '0;
		add_row(CMD_CLEAR, 20'd0, 32'd0, 32'd0, 1'b0, 1, cleared);
		add_row(CMD_STEP, 20'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 0, none);
		add_row(CMD_STEP, 20'd1, 32'd0, 32'h8000_0000, 1'b1, 0, none);
		add_row(CMD_STEP, 20'd2, 32'd5, 32'd0, 1'b1, 0, none);
		// Zero previous score with a zero score: the change saturates.
		add_row(CMD_STEP, 20'd3, 32'd5, 32'd0, 1'b1, 0, none);
		// Missing score leaves the previous score in place.
		add_row(CMD_STEP, 20'd4, 32'd7, 32'd12345, 1'b0, 0, none);
		for (k = 0; k < 5; k++) begin
			add_row(CMD_STEP, 20'(5 + k), 32'd3, 32'd1000 * (k + 1), 1'b1, 0, none);
		end
		for (k = 0; k < 4; k++) begin
			add_row(CMD_STEP, 20'(10 + k), 32'd2, 32'd4000 - 32'd500 * k, 1'b1, 0, none);
		end
		add_row(CMD_STEP, 20'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0, none);
		add_row(CMD_CLEAR, 20'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1, cleared);
		add_row(CMD_STEP, 20'd0, 32'd0, 32'd0, 1'b1, 0, none);
		add_row(CMD_STEP, 20'd1, 32'd1, 32'd65536, 1'b1, 0, none);
		add_row(CMD_STEP, 20'd2, 32'd1, 32'hFFFF_0000, 1'b1, 0, none);
		foreach (rows[i]) begin
			send_beat(rows[i]);
		end

		// Random part: mostly runs of consecutive iterations after a clear.
		it.fixed = 0;
		it.out = none;
		for (phase = 0; phase < 7; phase++) begin
			drain();
			if (phase > 0) begin
				configure(phase);
			end
			n = 0;
			while (n < 170) begin
				calm = ($urandom_range(0, 5) == 0);
				if (phase == 3 && n == 0) begin
					hold_long = 1;
				end
				k = $urandom_range(0, 9);
				if (k == 0) begin
					it.cmd = 1'($urandom_range(0, 1));
					it.idx = 20'($urandom);
					it.grad = $urandom;
					it.score = $urandom;
					it.sv = 1'($urandom_range(0, 1));
					send_beat(it);
					n++;
				end else begin
					it.cmd = CMD_CLEAR;
					it.idx = 20'($urandom);
					it.grad = $urandom;
					it.score = $urandom;
					it.sv = 1'($urandom_range(0, 1));
					send_beat(it);
					n++;
					len = $urandom_range(3, 40);
					gmode = $urandom_range(0, 2);
					sc = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 32'h0100_0000);
					g = $urandom;
					// A broken run starts somewhere other than zero.
					base = (k == 1) ? 20'($urandom) : 20'd0;
					for (int s = 0; s < len; s++) begin
						case ($urandom_range(0, 19))
							0: sc = $urandom;
							1: sc = 32'd0;
							2, 3: ;
							4, 5, 6, 7, 8: sc = sc + $urandom_range(1, 4096);
							default: sc = sc - $urandom_range(0, 4096);
						endcase
						case (gmode)
							0: g = $urandom_range(0, 100);
							1: g = g - (g >> 2);
							default: g = $urandom;
						endcase
						it.cmd = CMD_STEP;
						it.idx = base + s[19:0];
						it.grad = g;
						it.score = sc;
						it.sv = ($urandom_range(0, 19) != 0);
						send_beat(it);
						n++;
					end
				end
			end
		end
		calm = 0;
		drain();
		repeat (300) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
